[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sboc_pkg.sv]
`timescale 1ns / 1ps

package sboc_pkg;

  localparam int unsigned StoreW  = 14;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned GroupW  = 6;
  localparam int unsigned MaxRes  = 2;

  localparam logic [ByteW-1:0]  CharOffset  = 8'd60;
  localparam logic [CountW-1:0] EncCountMax = 4'd4;
  localparam logic [CountW-1:0] DecCountMax = 4'd7;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]              num;
    out_item_t [MaxRes-1:0]  res;
    logic [StoreW-1:0]       store;
    logic [CountW-1:0]       count;
  } step_t;

endpackage

[rtl/core/sboc_step.sv]
`timescale 1ns / 1ps

module sboc_step (
  input  sboc_pkg::mode_e              mode_i,
  input  sboc_pkg::in_item_t           item_i,
  input  logic [sboc_pkg::StoreW-1:0]  store_i,
  input  logic [sboc_pkg::CountW-1:0]  count_i,
  output sboc_pkg::step_t              result_o
);
  import sboc_pkg::*;

  logic [CountW-1:0] cnt_enc;
  logic [CountW-1:0] rem_enc;
  logic [StoreW-1:0] acc_enc;
  logic [StoreW-1:0] acc_enc_m;
  logic [GroupW-1:0] grp0;
  logic [GroupW-1:0] grp1;
  logic [GroupW-1:0] pad;
  logic [GroupW-1:0] six;
  logic [CountW-1:0] cnt_dec;
  logic [CountW-1:0] cnt6;
  logic [CountW-1:0] rem_dec;
  logic [StoreW-1:0] acc_dec;

  always_comb begin
    result_o = '0;

    cnt_enc   = (count_i > EncCountMax) ? EncCountMax : count_i;
    acc_enc   = {store_i[5:0], item_i.in_byte};
    grp1      = acc_enc[5:0];
    if (cnt_enc == EncCountMax) begin
      rem_enc = '0;
      grp0    = acc_enc[11:6];
    end else begin
      rem_enc = cnt_enc + 4'd2;
      grp0    = GroupW'(acc_enc >> rem_enc);
    end
    acc_enc_m = acc_enc & ((14'd1 << rem_enc) - 14'd1);
    pad       = GroupW'(acc_enc_m << (4'd6 - rem_enc));

    six     = GroupW'(item_i.in_byte - CharOffset);
    cnt_dec = (count_i > DecCountMax) ? DecCountMax : count_i;
    acc_dec = {store_i[7:0], six};
    cnt6    = cnt_dec + 4'd6;
    rem_dec = (cnt6 >= 4'd8) ? (cnt6 - 4'd8) : cnt6;

    case (mode_i)
      MODE_ENCODE: begin
        result_o.res[0].out_byte = {2'b00, grp0} + CharOffset;
        result_o.store           = acc_enc_m;
        result_o.count           = rem_enc;
        if (cnt_enc == EncCountMax) begin
          result_o.num             = 2'd2;
          result_o.res[1].out_byte = {2'b00, grp1} + CharOffset;
        end else if (item_i.in_last && (rem_enc != '0)) begin
          result_o.num             = 2'd2;
          result_o.res[1].out_byte = {2'b00, pad} + CharOffset;
        end else begin
          result_o.num = 2'd1;
        end
      end
      MODE_DECODE: begin
        result_o.res[0].out_byte = ByteW'(acc_dec >> rem_dec);
        result_o.num             = (cnt6 >= 4'd8) ? 2'd1 : 2'd0;
        result_o.store           = acc_dec & ((14'd1 << rem_dec) - 14'd1);
        result_o.count           = rem_dec;
      end
      default: begin
        result_o.num = 2'd0;
      end
    endcase

    case (result_o.num)
      2'd1:    result_o.res[0].run_last = 1'b1;
      2'd2:    result_o.res[1].run_last = 1'b1;
      default: result_o.res[0].run_last = 1'b0;
    endcase

    if (item_i.in_last) begin
      result_o.store = '0;
      result_o.count = '0;
    end
  end

endmodule

[rtl/core/six_bit_offset_codec_top.sv]
`timescale 1ns / 1ps

// channel  valid        stall        payload
// in       in_valid_i   in_stall_o   in_item_i  (in_byte, in_last)
// out      out_valid_o  out_stall_i  out_item_o (out_byte, run_last)
// cfg      cfg_we_i     -            cfg_wdata_i (mode)
//
// An accepted item is held in the input register, then is coded in one pass.
// Results leave through a two-entry output buffer, one per cycle while out_stall_i
// is low. Each item yields up to two characters; one output port sets the pace.
// Reset clears mode to encode and empties the bit store; no clearing pass.
// A stall on the output holds the head item and backs up into the input register.

module six_bit_offset_codec_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sboc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sboc_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);
  import sboc_pkg::*;

  `include "assert_macros.svh"

  mode_e              mode_q;
  logic [StoreW-1:0]  store_q;
  logic [CountW-1:0]  count_q;
  in_item_t           in_q;
  logic               in_vld_q;
  logic               in_vld_d;
  out_item_t [1:0]    ob_q;
  out_item_t [1:0]    ob_d;
  logic [1:0]         ob_cnt_q;
  logic [1:0]         ob_cnt_d;
  logic               pop;
  logic [1:0]         keep;
  logic [1:0]         room;
  logic               fire;
  logic               in_accept;
  step_t              step;

  sboc_step u_step (
    .mode_i   (mode_q),
    .item_i   (in_q),
    .store_i  (store_q),
    .count_i  (count_q),
    .result_o (step)
  );

  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign out_item_o  = ob_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign keep        = ob_cnt_q - {1'b0, pop};
  assign room        = 2'd2 - keep;
  assign fire        = in_vld_q && (step.num <= room);
  assign in_stall_o  = in_vld_q && !fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_accept || (in_vld_q && !fire);

  always_comb begin
    ob_d = ob_q;
    if (pop) begin
      ob_d[0] = ob_q[1];
    end
    if (fire && (step.num != 2'd0)) begin
      if (keep == 2'd0) begin
        ob_d[0] = step.res[0];
        ob_d[1] = step.res[1];
      end else begin
        ob_d[1] = step.res[0];
      end
    end
    ob_cnt_d = keep + (fire ? step.num : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ENCODE;
      store_q  <= '0;
      count_q  <= '0;
      in_vld_q <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      ob_cnt_q <= ob_cnt_d;
      if (cfg_we_i) begin
        mode_q  <= mode_e'(cfg_wdata_i);
        store_q <= '0;
        count_q <= '0;
      end else if (fire) begin
        store_q <= step.store;
        count_q <= step.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  `ASSERT_ALWAYS(a_ob_cnt_max, ob_cnt_q <= 2'd2, "output buffer overfilled")
  `ASSERT_IMPL(a_enc_count, mode_q == MODE_ENCODE, count_q <= EncCountMax, "encode count high")
  `ASSERT_NEXT(a_last_clear, fire && in_q.in_last, count_q == '0, "store not cleared on last")

endmodule
